@@ rtl/itpc_pkg.sv @@
`timescale 1ns / 1ps

package itpc_pkg;

    // Input token kinds
    localparam logic [2:0] K_OPERAND = 3'd0;
    localparam logic [2:0] K_PLUS    = 3'd1;
    localparam logic [2:0] K_MINUS   = 3'd2;
    localparam logic [2:0] K_TIMES   = 3'd3;
    localparam logic [2:0] K_DIVIDE  = 3'd4;
    localparam logic [2:0] K_OPEN    = 3'd5;
    localparam logic [2:0] K_CLOSE   = 3'd6;
    localparam logic [2:0] K_END     = 3'd7;

    // Output kind for the end-of-expression marker
    localparam logic [2:0] OUT_END = 3'd5;

    // Status codes carried by the end marker
    localparam logic [2:0] ST_OK        = 3'd0;
    localparam logic [2:0] ST_OVERFLOW  = 3'd1;
    localparam logic [2:0] ST_UNM_CLOSE = 3'd2;
    localparam logic [2:0] ST_UNM_OPEN  = 3'd3;
    localparam logic [2:0] ST_MISPLACED = 3'd4;

    // Token queue between front and back
    localparam int QUEUE_DEPTH = 2;
    localparam int QUEUE_AW    = 1;

    typedef struct packed {
        logic [2:0]  token_kind;
        logic [30:0] operand_value;
    } t_in_item;

    typedef struct packed {
        logic [2:0]  out_kind;
        logic [30:0] out_value;
        logic        out_last;
        logic [2:0]  out_status;
    } t_out_item;

    typedef enum logic [2:0] {
        C_OPERAND,
        C_OPER,
        C_OPEN,
        C_CLOSE,
        C_END
    } t_cls;

    // Classified token as it sits in the queue
    typedef struct packed {
        t_cls        cls;
        logic [2:0]  kind;
        logic        hi_prec;
        logic [30:0] value;
    } t_cls_item;

    // * and / bind tighter than + and -
    function automatic logic f_hi_prec(input logic [2:0] kind);
        f_hi_prec = (kind == K_TIMES) || (kind == K_DIVIDE);
    endfunction

endpackage

@@ rtl/itpc_ram.sv @@
`timescale 1ns / 1ps

module itpc_ram #(
    parameter int WIDTH = 3,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // one write port, one registered read port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

@@ rtl/itpc_front.sv @@
`timescale 1ns / 1ps

module itpc_front
    import itpc_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_valid,
    output logic      o_ready,
    input  t_in_item  i_data,
    output logic      o_q_valid,
    output t_cls_item o_q_item,
    input  logic      i_q_deq
);

    t_cls_item r_mem [QUEUE_DEPTH];
    logic [QUEUE_AW-1:0] r_wp;
    logic [QUEUE_AW-1:0] r_rp;
    logic [QUEUE_AW:0]   r_cnt;
    t_cls_item           w_cls;
    logic                w_wr;
    logic                w_rd;

    // classify the incoming word
    always_comb begin
        w_cls.kind    = i_data.token_kind;
        w_cls.hi_prec = f_hi_prec(i_data.token_kind);
        w_cls.value   = i_data.operand_value;
        case (i_data.token_kind)
            K_OPERAND:                            w_cls.cls = C_OPERAND;
            K_PLUS, K_MINUS, K_TIMES, K_DIVIDE:   w_cls.cls = C_OPER;
            K_OPEN:                               w_cls.cls = C_OPEN;
            K_CLOSE:                              w_cls.cls = C_CLOSE;
            default:                              w_cls.cls = C_END;
        endcase
    end

    assign o_ready   = (r_cnt != (QUEUE_AW+1)'(QUEUE_DEPTH));
    assign w_wr      = i_valid && o_ready;
    assign o_q_valid = (r_cnt != '0);
    assign w_rd      = i_q_deq && o_q_valid;
    assign o_q_item  = r_mem[r_rp];

    // small token queue
    always_ff @(posedge i_clk) begin
        if (w_wr) begin
            r_mem[r_wp] <= w_cls;
        end
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (w_wr) begin
                r_wp <= r_wp + 1'b1;
            end
            if (w_rd) begin
                r_rp <= r_rp + 1'b1;
            end
            if (w_wr && !w_rd) begin
                r_cnt <= r_cnt + 1'b1;
            end else if (w_rd && !w_wr) begin
                r_cnt <= r_cnt - 1'b1;
            end
        end
    end

endmodule

@@ rtl/itpc_back.sv @@
`timescale 1ns / 1ps

module itpc_back
    import itpc_pkg::*;
#(
    parameter int STACK_DEPTH = 16
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_q_valid,
    input  t_cls_item                      i_q_item,
    output logic                           o_q_deq,
    output logic                           o_valid,
    input  logic                           i_ready,
    output t_out_item                      o_data,
    output logic [$clog2(STACK_DEPTH+1)-1:0] o_count
);

    localparam int AW = $clog2(STACK_DEPTH);
    localparam int CW = $clog2(STACK_DEPTH+1);

    typedef enum logic [1:0] {
        S_DECIDE,
        S_RELOAD,
        S_FINISH
    } t_state;

    t_state    r_state, n_state;
    logic [CW-1:0] r_count, n_count;
    logic [2:0] r_top, n_top;
    logic      r_expect, n_expect;
    logic [2:0] r_err, n_err;
    logic      r_fin, n_fin;
    logic      r_pend_v, n_pend_v;
    t_out_item r_pend, n_pend;
    logic      r_out_v;
    t_out_item r_out;

    logic      w_out_free;
    logic      w_can_emit;
    logic      w_emit;
    t_out_item w_emit_item;
    logic      w_done;
    logic      w_push;
    logic [2:0] w_push_code;
    logic      w_out_load;
    t_out_item w_out_item;
    logic      w_we;
    logic [2:0] w_rdata;
    logic [2:0] w_eff_err;

    function automatic logic [2:0] f_flag(input logic [2:0] err, input logic [2:0] code);
        f_flag = (err == ST_OK) ? code : err;
    endfunction

    function automatic t_out_item f_op_item(input logic [2:0] kind);
        t_out_item it;
        it.out_kind   = kind;
        it.out_value  = '0;
        it.out_last   = 1'b0;
        it.out_status = ST_OK;
        f_op_item = it;
    endfunction

    assign w_out_free = !r_out_v || i_ready;
    assign w_can_emit = !r_pend_v || w_out_free;
    assign w_eff_err  = r_expect ? f_flag(r_err, ST_MISPLACED) : r_err;

    // operator stack storage; top entry is also cached in r_top
    itpc_ram #(
        .WIDTH (3),
        .DEPTH (STACK_DEPTH)
    ) u_stack (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr (r_count[AW-1:0]),
        .i_wdata (w_push_code),
        .i_raddr (AW'(r_count - CW'(2))),
        .o_rdata (w_rdata)
    );

    // sequencer: one stack action per step
    always_comb begin
        n_state     = r_state;
        n_count     = r_count;
        n_top       = r_top;
        n_expect    = r_expect;
        n_err       = r_err;
        n_fin       = r_fin;
        w_emit      = 1'b0;
        w_emit_item = f_op_item(r_top);
        w_done      = 1'b0;
        w_push      = 1'b0;
        w_push_code = i_q_item.kind;
        o_q_deq     = 1'b0;
        case (r_state)
            S_DECIDE: begin
                if (i_q_valid) begin
                    case (i_q_item.cls)
                        C_OPERAND: begin
                            if (r_expect) begin
                                if (w_can_emit) begin
                                    w_emit                 = 1'b1;
                                    w_emit_item            = f_op_item(K_OPERAND);
                                    w_emit_item.out_value  = i_q_item.value;
                                    n_expect               = 1'b0;
                                    w_done                 = 1'b1;
                                end
                            end else begin
                                n_err  = f_flag(r_err, ST_MISPLACED);
                                w_done = 1'b1;
                            end
                        end
                        C_OPER: begin
                            if (r_expect) begin
                                n_err  = f_flag(r_err, ST_MISPLACED);
                                w_done = 1'b1;
                            end else if (r_count != '0 && r_top != K_OPEN &&
                                         (f_hi_prec(r_top) || !i_q_item.hi_prec)) begin
                                if (w_can_emit) begin
                                    w_emit  = 1'b1;
                                    n_count = r_count - 1'b1;
                                    n_fin   = 1'b0;
                                    n_state = S_RELOAD;
                                end
                            end else begin
                                w_push   = 1'b1;
                                n_expect = 1'b1;
                                w_done   = 1'b1;
                            end
                        end
                        C_OPEN: begin
                            if (r_expect) begin
                                w_push      = 1'b1;
                                w_push_code = K_OPEN;
                            end else begin
                                n_err = f_flag(r_err, ST_MISPLACED);
                            end
                            w_done = 1'b1;
                        end
                        C_CLOSE: begin
                            if (r_expect) begin
                                n_err  = f_flag(r_err, ST_MISPLACED);
                                w_done = 1'b1;
                            end else if (r_count == '0) begin
                                n_err  = f_flag(r_err, ST_UNM_CLOSE);
                                w_done = 1'b1;
                            end else if (r_top == K_OPEN) begin
                                // matching paren: drop it, token is finished
                                n_count = r_count - 1'b1;
                                n_fin   = 1'b1;
                                n_state = S_RELOAD;
                                o_q_deq = 1'b1;
                            end else if (w_can_emit) begin
                                w_emit  = 1'b1;
                                n_count = r_count - 1'b1;
                                n_fin   = 1'b0;
                                n_state = S_RELOAD;
                            end
                        end
                        default: begin
                            // end: flush stack, then give the marker
                            if (r_count != '0) begin
                                if (r_top == K_OPEN) begin
                                    n_err   = f_flag(w_eff_err, ST_UNM_OPEN);
                                    n_count = r_count - 1'b1;
                                    n_fin   = 1'b0;
                                    n_state = S_RELOAD;
                                end else if (w_can_emit) begin
                                    w_emit  = 1'b1;
                                    n_err   = w_eff_err;
                                    n_count = r_count - 1'b1;
                                    n_fin   = 1'b0;
                                    n_state = S_RELOAD;
                                end
                            end else if (w_can_emit) begin
                                w_emit                 = 1'b1;
                                w_emit_item            = f_op_item(OUT_END);
                                w_emit_item.out_status = w_eff_err;
                                n_count                = '0;
                                n_expect               = 1'b1;
                                n_err                  = ST_OK;
                                w_done                 = 1'b1;
                            end
                        end
                    endcase
                end
            end
            S_RELOAD: begin
                n_top = w_rdata;
                if (r_fin && r_pend_v) begin
                    n_state = S_FINISH;
                end else begin
                    n_state = S_DECIDE;
                end
            end
            S_FINISH: begin
                if (w_out_free) begin
                    n_state = S_DECIDE;
                end
            end
            default: begin
                n_state = S_DECIDE;
            end
        endcase

        // push onto the stack, or flag a full stack
        w_we = 1'b0;
        if (w_push) begin
            if (r_count == CW'(STACK_DEPTH)) begin
                n_err = f_flag(r_err, ST_OVERFLOW);
            end else begin
                w_we    = 1'b1;
                n_top   = w_push_code;
                n_count = r_count + 1'b1;
            end
        end

        // pending word holds back one result so its last bit is known
        n_pend_v   = r_pend_v;
        n_pend     = r_pend;
        w_out_load = 1'b0;
        w_out_item = r_pend;
        if (w_emit) begin
            n_pend   = w_emit_item;
            n_pend_v = 1'b1;
            if (r_pend_v) begin
                w_out_load = 1'b1;
            end
        end
        if (r_state == S_FINISH && w_out_free) begin
            w_out_load          = 1'b1;
            w_out_item.out_last = 1'b1;
            n_pend_v            = 1'b0;
        end

        if (w_done) begin
            o_q_deq = 1'b1;
            n_state = n_pend_v ? S_FINISH : S_DECIDE;
        end
    end

    always_ff @(posedge i_clk) begin
        r_top  <= n_top;
        r_pend <= n_pend;
        if (w_out_load) begin
            r_out <= w_out_item;
        end
        if (!i_rst_n) begin
            r_state  <= S_DECIDE;
            r_count  <= '0;
            r_expect <= 1'b1;
            r_err    <= ST_OK;
            r_fin    <= 1'b0;
            r_pend_v <= 1'b0;
            r_out_v  <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_count  <= n_count;
            r_expect <= n_expect;
            r_err    <= n_err;
            r_fin    <= n_fin;
            r_pend_v <= n_pend_v;
            if (w_out_load) begin
                r_out_v <= 1'b1;
            end else if (i_ready) begin
                r_out_v <= 1'b0;
            end
        end
    end

    assign o_valid = r_out_v;
    assign o_data  = r_out;
    assign o_count = r_count;

endmodule

@@ rtl/infix_to_postfix_converter_unit.sv @@
`timescale 1ns / 1ps

// Infix to postfix converter (shunting yard).
// Input channel i_valid/o_ready carries one token word: operand, + - * /,
// open paren, close paren or end. Output channel o_valid/i_ready carries
// postfix words; out_last marks the last word caused by one input token, and
// the end marker carries the sticky status of the expression.
// A token is taken into a two-word queue and classified; the back end
// then works on the queue head with the operator stack.
// An operand takes a decide step plus the hand-off of the held-back word; a
// plain push, or a token that only flags, takes the decide step alone. Each
// stack pop adds a reload step in which the registered read port of the stack
// RAM refills the cached top entry; an end token pops every entry, then gives
// the marker. A word passes the queue, pending and output registers to o_valid.
// Reset clears the stack count, status and all valid flags; the stack
// contents need no clearing. When the receiver stalls, the output register
// holds its word, the back end stops at its next result, and the queue
// keeps accepting until it holds two tokens.

module infix_to_postfix_converter_unit
    import itpc_pkg::*;
#(
    parameter int STACK_DEPTH = 16
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_valid,
    output logic      o_ready,
    input  t_in_item  i_data,
    output logic      o_valid,
    input  logic      i_ready,
    output t_out_item o_data
);

    logic      w_q_valid;
    t_cls_item w_q_item;
    logic      w_q_deq;
    logic [$clog2(STACK_DEPTH+1)-1:0] w_count;

    itpc_front u_front (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_valid   (i_valid),
        .o_ready   (o_ready),
        .i_data    (i_data),
        .o_q_valid (w_q_valid),
        .o_q_item  (w_q_item),
        .i_q_deq   (w_q_deq)
    );

    itpc_back #(
        .STACK_DEPTH (STACK_DEPTH)
    ) u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_q_valid (w_q_valid),
        .i_q_item  (w_q_item),
        .o_q_deq   (w_q_deq),
        .o_valid   (o_valid),
        .i_ready   (i_ready),
        .o_data    (o_data),
        .o_count   (w_count)
    );

    // stack never grows past its depth
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_count <= ($clog2(STACK_DEPTH+1))'(STACK_DEPTH))
        else $error("stack count beyond depth");

    // end marker always closes its token
    a_end_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_data.out_kind == OUT_END |-> o_data.out_last)
        else $error("end marker without last");

    // status only rides on the end marker
    a_status_end: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_data.out_kind != OUT_END |-> o_data.out_status == ST_OK)
        else $error("status on a non-end word");

    // stack is empty right after an end marker is produced
    a_end_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_q_deq && w_q_valid && w_q_item.cls == C_END |=> w_count == '0)
        else $error("stack not empty after end");

endmodule

@@ test/infix_to_postfix_converter_unit_tb.sv @@
`timescale 1ns / 1ps

module infix_to_postfix_converter_unit_tb;
    import itpc_pkg::*;

    localparam int STACK_DEPTH  = 16;
    localparam int IDLE_LIMIT   = 5000;
    localparam int TAIL_CYCLES  = 40;
    localparam int PHASE_TOKENS = 86;

    logic      i_clk   = 1'b0;
    logic      i_rst_n = 1'b0;
    logic      i_valid = 1'b0;
    logic      o_ready;
    t_in_item  i_data  = '0;
    logic      o_valid;
    logic      i_ready = 1'b0;
    t_out_item o_data;

    // One directed row: token, and optionally the word it must produce
    typedef struct packed {
        t_in_item  tok;
        logic      pinned;
        t_out_item word;
    } t_script_row;

    // Shunting-yard shadow state
    logic [2:0]  op_stack [STACK_DEPTH];
    int unsigned op_depth;
    bit          want_operand;
    logic [2:0]  expr_status;

    t_out_item   shunt_words [$];   // words caused by the current token
    t_out_item   postfix_due [$];   // words still to come from the block
    t_in_item    expr_toks [$];     // tokens of the expression being built
    t_script_row script [$];

    int snd_idle_pct  = 0;
    int rcv_stall_pct = 0;
    int err_cnt       = 0;
    int tokens_in     = 0;
    int words_checked = 0;
    int stall_cycles  = 0;
    int end_seen [8];

    infix_to_postfix_converter_unit #(
        .STACK_DEPTH(STACK_DEPTH)
    ) dut (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_valid(i_valid),
        .o_ready(o_ready),
        .i_data (i_data),
        .o_valid(o_valid),
        .i_ready(i_ready),
        .o_data (o_data)
    );

    always #1 i_clk = ~i_clk;

    // ---------------------------------------------------------------
    // Prediction
    // ---------------------------------------------------------------

    function automatic int op_rank(input logic [2:0] kind);
        return (kind == K_TIMES || kind == K_DIVIDE) ? 2 : 1;
    endfunction

    function automatic void note_error(input logic [2:0] code);
        if (expr_status == ST_OK) expr_status = code;
    endfunction

    function automatic void put_word(input logic [2:0] kind, input logic [30:0] value,
                                     input logic [2:0] status);
        t_out_item w;
        w.out_kind   = kind;
        w.out_value  = value;
        w.out_last   = 1'b0;
        w.out_status = status;
        shunt_words.push_back(w);
    endfunction

    function automatic void push_op(input logic [2:0] kind);
        if (op_depth >= STACK_DEPTH) begin
            note_error(ST_OVERFLOW);
        end else begin
            op_stack[op_depth] = kind;
            op_depth++;
        end
    endfunction

    function automatic void clear_expr();
        op_depth     = 0;
        want_operand = 1'b1;
        expr_status  = ST_OK;
    endfunction

    // Advance the shadow state by one token, leave its words in shunt_words
    function automatic void shunt_token(input t_in_item tok);
        logic [2:0] kind;
        logic [2:0] t;
        bit         found;
        kind = tok.token_kind;
        shunt_words.delete();
        if (kind == K_OPERAND) begin
            if (want_operand) begin
                put_word(K_OPERAND, tok.operand_value, ST_OK);
                want_operand = 1'b0;
            end else begin
                note_error(ST_MISPLACED);
            end
        end else if (kind >= K_PLUS && kind <= K_DIVIDE) begin
            if (want_operand) begin
                note_error(ST_MISPLACED);
            end else begin
                // left-assoc: pop while top binds at least as tight
                while (op_depth > 0 && op_stack[op_depth - 1] != K_OPEN &&
                       op_rank(op_stack[op_depth - 1]) >= op_rank(kind)) begin
                    put_word(op_stack[op_depth - 1], '0, ST_OK);
                    op_depth--;
                end
                push_op(kind);
                want_operand = 1'b1;
            end
        end else if (kind == K_OPEN) begin
            if (want_operand) push_op(K_OPEN);
            else note_error(ST_MISPLACED);
        end else if (kind == K_CLOSE) begin
            if (want_operand) begin
                note_error(ST_MISPLACED);
            end else begin
                found = 1'b0;
                while (op_depth > 0 && !found) begin
                    t = op_stack[op_depth - 1];
                    op_depth--;
                    if (t == K_OPEN) found = 1'b1;
                    else put_word(t, '0, ST_OK);
                end
                if (!found) note_error(ST_UNM_CLOSE);
            end
        end else begin
            // end token: flush, then the marker with the sticky status
            if (want_operand) note_error(ST_MISPLACED);
            while (op_depth > 0) begin
                t = op_stack[op_depth - 1];
                op_depth--;
                if (t == K_OPEN) note_error(ST_UNM_OPEN);
                else put_word(t, '0, ST_OK);
            end
            put_word(OUT_END, '0, expr_status);
            clear_expr();
        end
        if (shunt_words.size() > 0) shunt_words[$].out_last = 1'b1;
    endfunction

    // ---------------------------------------------------------------
    // Stimulus helpers
    // ---------------------------------------------------------------

    function automatic t_in_item mk_tok(input logic [2:0] kind, input logic [30:0] value);
        t_in_item tok;
        tok.token_kind    = kind;
        tok.operand_value = value;
        return tok;
    endfunction

    function automatic t_script_row predicted_row(input logic [2:0] kind,
                                                  input logic [30:0] value);
        t_script_row r;
        r.tok    = mk_tok(kind, value);
        r.pinned = 1'b0;
        r.word   = '0;
        return r;
    endfunction

    function automatic t_script_row pinned_row(input logic [2:0] kind, input logic [30:0] value,
                                               input logic [2:0] okind,
                                               input logic [30:0] ovalue,
                                               input logic [2:0] ostatus);
        t_script_row r;
        r.tok             = mk_tok(kind, value);
        r.pinned          = 1'b1;
        r.word.out_kind   = okind;
        r.word.out_value  = ovalue;
        r.word.out_last   = 1'b1;
        r.word.out_status = ostatus;
        return r;
    endfunction

    // Operand values lean on the extremes now and then
    function automatic logic [30:0] pick_value();
        case ($urandom_range(7))
            0:       return '0;
            1:       return '1;
            default: return 31'($urandom);
        endcase
    endfunction

    function automatic void add_tok(input logic [2:0] kind);
        expr_toks.push_back(mk_tok(kind, (kind == K_OPERAND) ? pick_value() : 31'($urandom)));
    endfunction

    // Expression with random content, mostly well-formed; deep ones may overrun the stack
    function automatic void build_expression(input bit deep);
        int   nest;
        int   opnds;
        int   goal;
        int   pos;
        bit   need;
        bit   done;
        logic [2:0] op;
        expr_toks.delete();
        nest  = 0;
        opnds = 0;
        need  = 1'b1;
        done  = 1'b0;
        goal  = $urandom_range(1, 6);
        if (deep) begin
            repeat ($urandom_range(12, 20)) begin
                add_tok(K_OPEN);
                nest++;
            end
        end
        while (!done) begin
            if (need) begin
                if (nest < 8 && $urandom_range(99) < 20) begin
                    add_tok(K_OPEN);
                    nest++;
                end else begin
                    add_tok(K_OPERAND);
                    need = 1'b0;
                    opnds++;
                end
            end else if (nest > 0 && ($urandom_range(99) < 35 || opnds >= goal)) begin
                add_tok(K_CLOSE);
                nest--;
            end else if (opnds >= goal) begin
                done = 1'b1;
            end else begin
                op = 3'($urandom_range(K_PLUS, K_DIVIDE));
                add_tok(op);
                need = 1'b1;
            end
        end
        add_tok(K_END);
        // some expressions get broken: a token replaced, added or dropped
        if ($urandom_range(5) == 0) begin
            pos = $urandom_range(0, expr_toks.size() - 1);
            case ($urandom_range(2))
                0: expr_toks[pos] = mk_tok(3'($urandom_range(7)), 31'($urandom));
                1: expr_toks.insert(pos, mk_tok(3'($urandom_range(7)), 31'($urandom)));
                default: expr_toks.delete(pos);
            endcase
        end
    endfunction

    // Offer one word, wait for acceptance, then queue what it should produce
    task automatic send_token(input t_in_item tok, input logic pinned, input t_out_item word);
        while ($urandom_range(99) < snd_idle_pct) begin
            i_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_valid <= 1'b1;
        i_data  <= tok;
        @(posedge i_clk);
        while (!o_ready) @(posedge i_clk);
        tokens_in++;
        shunt_token(tok);
        if (pinned) postfix_due.push_back(word);
        else foreach (shunt_words[i]) postfix_due.push_back(shunt_words[i]);
    endtask

    // Sender holds off until the block has delivered everything
    task automatic drain();
        i_valid <= 1'b0;
        do @(posedge i_clk); while (postfix_due.size() != 0);
    endtask

    // ---------------------------------------------------------------
    // Output side: stall at random and check each word taken
    // ---------------------------------------------------------------

    task automatic check_word(input t_out_item got);
        t_out_item want;
        if (postfix_due.size() == 0) begin
            $error("unexpected word: kind %0d value %0d last %0d status %0d",
                   got.out_kind, got.out_value, got.out_last, got.out_status);
            err_cnt++;
        end else begin
            want = postfix_due.pop_front();
            words_checked++;
            if (got.out_kind != want.out_kind) begin
                $error("out_kind: expected %0d, got %0d", want.out_kind, got.out_kind);
                err_cnt++;
            end
            if (got.out_value != want.out_value) begin
                $error("out_value: expected %0d, got %0d", want.out_value, got.out_value);
                err_cnt++;
            end
            if (got.out_last != want.out_last) begin
                $error("out_last: expected %0d, got %0d", want.out_last, got.out_last);
                err_cnt++;
            end
            if (got.out_status != want.out_status) begin
                $error("out_status: expected %0d, got %0d", want.out_status, got.out_status);
                err_cnt++;
            end
            if (want.out_kind == OUT_END) end_seen[want.out_status]++;
        end
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_ready <= 1'b0;
        end else begin
            if (o_valid && i_ready) check_word(o_data);
            i_ready <= ($urandom_range(99) >= rcv_stall_pct);
        end
    end

    // Watchdog: too long without any word moving on either side
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if ((i_valid && o_ready) || (o_valid && i_ready)) begin
                stall_cycles <= 0;
            end else if (stall_cycles >= IDLE_LIMIT) begin
                $display("timeout: no word moved for %0d cycles", IDLE_LIMIT);
                $display("infix_to_postfix_converter_unit_tb: done, errors");
                $finish;
            end else begin
                stall_cycles <= stall_cycles + 1;
            end
        end
    end

    // ---------------------------------------------------------------
    // Main sequence
    // ---------------------------------------------------------------

    initial begin
        int directed_cnt;
        int sent;
        clear_expr();
        foreach (end_seen[i]) end_seen[i] = 0;

        // value range, all four operators, parens, then misplaced, unmatched close and unmatched open endings
        script = '{
            pinned_row(K_END,     '0, OUT_END, '0, ST_MISPLACED),     // empty expression
            pinned_row(K_OPERAND, '1, K_OPERAND, '1, ST_OK),
            predicted_row(K_PLUS, '1),
            pinned_row(K_OPERAND, '0, K_OPERAND, '0, ST_OK),
            predicted_row(K_TIMES, '0),
            predicted_row(K_OPEN, 31'h2AAA_AAAA),
            predicted_row(K_OPERAND, 31'h2AAA_AAAA),
            predicted_row(K_MINUS, 31'h5555_5555),
            predicted_row(K_OPERAND, 31'h5555_5555),
            predicted_row(K_CLOSE, '0),
            predicted_row(K_DIVIDE, '0),
            predicted_row(K_OPERAND, 31'd9),
            predicted_row(K_END, '0),
            pinned_row(K_OPERAND, 31'd1, K_OPERAND, 31'd1, ST_OK),
            predicted_row(K_CLOSE, '0),                               // close with empty stack
            pinned_row(K_END,     '0, OUT_END, '0, ST_UNM_CLOSE),
            predicted_row(K_OPEN, '0),
            pinned_row(K_OPERAND, 31'd2, K_OPERAND, 31'd2, ST_OK),
            pinned_row(K_END,     '0, OUT_END, '0, ST_UNM_OPEN),      // open left on stack
            pinned_row(K_OPERAND, 31'd3, K_OPERAND, 31'd3, ST_OK),
            predicted_row(K_OPERAND, 31'd4),                          // operand out of place
            predicted_row(K_OPEN, '0),                                // open out of place
            predicted_row(K_MINUS, '0),
            predicted_row(K_TIMES, '0),                               // operator out of place
            predicted_row(K_END, '0)                                  // dangling end
        };

        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (script[i]) send_token(script[i].tok, script[i].pinned, script[i].word);
        directed_cnt = tokens_in;
        drain();

        // random expressions under four idling mixes, drained between them
        for (int ph = 0; ph < 4; ph++) begin
            case (ph)
                0:       begin snd_idle_pct = 0;  rcv_stall_pct = 0;  end
                1:       begin snd_idle_pct = 73; rcv_stall_pct = 0;  end
                2:       begin snd_idle_pct = 0;  rcv_stall_pct = 73; end
                default: begin snd_idle_pct = 28; rcv_stall_pct = 28; end
            endcase
            sent = 0;
            while (sent < PHASE_TOKENS) begin
                build_expression((ph == 0 && sent == 0) || $urandom_range(9) == 0);
                foreach (expr_toks[i]) send_token(expr_toks[i], 1'b0, '0);
                sent += expr_toks.size();
            end
            drain();
        end

        // block may still be chewing on tokens that give no word
        repeat (TAIL_CYCLES) @(posedge i_clk);

        $display("%0d tokens in (%0d directed), %0d postfix words checked",
                 tokens_in, directed_cnt, words_checked);
        $display("expression endings: ok %0d, overflow %0d, unmatched close %0d, %s %0d, %s %0d",
                 end_seen[ST_OK], end_seen[ST_OVERFLOW], end_seen[ST_UNM_CLOSE],
                 "unmatched open", end_seen[ST_UNM_OPEN], "misplaced", end_seen[ST_MISPLACED]);
        if (err_cnt == 0) begin
            $display("infix_to_postfix_converter_unit_tb: done, clean");
        end else begin
            $display("infix_to_postfix_converter_unit_tb: done, errors");
        end
        $finish;
    end

endmodule

@@ files.f @@
rtl/itpc_pkg.sv
rtl/itpc_ram.sv
rtl/itpc_front.sv
rtl/itpc_back.sv
rtl/infix_to_postfix_converter_unit.sv
test/infix_to_postfix_converter_unit_tb.sv
